// ===== sv/hsic_pkg.sv =====
// Shared types and constants for the hard-sphere insertion check unit.
// No dependencies; imported by hsic_dist, the top level, the checker and the testbench.
package hsic_pkg;

    // Width of the squared contact distance register (Q16.16 squared units).
    localparam int unsigned DIST_SQ_W = 34;

    typedef logic [DIST_SQ_W-1:0] t_dist_sq;

    // Reset value of the contact distance: (2 * 2.0)^2 in Q16.16.
    localparam t_dist_sq CONTACT_RESET = t_dist_sq'(1048576);

    // Result status codes.
    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_OVERLAP  = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

endpackage

// ===== sv/hsic_cell.sv =====
// One storage cell of the sphere ring: holds one stored center (x, y, z).
// Depends on nothing but its parameter; instantiated in a ring by the top level.
module hsic_cell #(
    parameter int unsigned ENTRY_W = 48
) (
    input  logic               i_clk,
    input  logic               i_shift,
    input  logic               i_load,
    input  logic [ENTRY_W-1:0] i_load_data,
    input  logic [ENTRY_W-1:0] i_prev,
    output logic [ENTRY_W-1:0] o_data
);

    logic [ENTRY_W-1:0] r_pos;
    logic [ENTRY_W-1:0] n_pos;

    // A load only happens while the ring is at rest, so it never meets a shift.
    always_comb begin
        n_pos = r_pos;
        if (i_load) begin
            n_pos = i_load_data;
        end else if (i_shift) begin
            n_pos = i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
    end

    assign o_data = r_pos;

endmodule

// ===== sv/hsic_dist.sv =====
// Three-stage squared-distance and overlap compare between a candidate and one stored center.
// Depends on hsic_pkg for the contact distance type.
module hsic_dist #(
    parameter int unsigned COORD_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [3*COORD_BITS-1:0]   i_cand,
    input  logic [3*COORD_BITS-1:0]   i_entry,
    input  hsic_pkg::t_dist_sq        i_limit,
    output logic                      o_hit
);
    import hsic_pkg::*;

    localparam int unsigned SUM_W = 2 * COORD_BITS + 2;
    localparam int unsigned CMP_W = (SUM_W > DIST_SQ_W) ? SUM_W : DIST_SQ_W;

    logic                    r_v1;
    logic                    r_v2;
    logic                    r_hit;
    logic [COORD_BITS-1:0]   r_mag [3];
    logic [2*COORD_BITS-1:0] r_sq  [3];
    logic [COORD_BITS-1:0]   n_mag [3];
    logic [CMP_W-1:0]        w_sum;

    // Stage 1: per-axis difference and its magnitude (always fits in COORD_BITS).
    always_comb begin
        logic signed [COORD_BITS:0] a;
        logic signed [COORD_BITS:0] b;
        logic signed [COORD_BITS:0] d;
        for (int k = 0; k < 3; k++) begin
            a = $signed({i_cand[k*COORD_BITS + COORD_BITS-1],
                         i_cand[k*COORD_BITS +: COORD_BITS]});
            b = $signed({i_entry[k*COORD_BITS + COORD_BITS-1],
                         i_entry[k*COORD_BITS +: COORD_BITS]});
            d = a - b;
            if (d[COORD_BITS]) begin
                d = -d;
            end
            n_mag[k] = d[COORD_BITS-1:0];
        end
    end

    // Stage 3 input: exact sum of the three squares.
    assign w_sum = CMP_W'(r_sq[0]) + CMP_W'(r_sq[1]) + CMP_W'(r_sq[2]);

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_mag[k] <= n_mag[k];
            r_sq[k]  <= r_mag[k] * r_mag[k];
        end
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            r_v1  <= i_valid;
            r_v2  <= r_v1;
            r_hit <= r_v2 && (w_sum <= CMP_W'(i_limit));
        end
    end

    assign o_hit = r_hit;

endmodule

// ===== sv/hard_sphere_insertion_check_unit.sv =====
// Top level of the hard-sphere insertion check: ring of storage cells, control and result port.
// Depends on hsic_pkg, hsic_cell and hsic_dist.
//
// A candidate center is transferred at a rising edge where start is high and busy is low.
// Unless the store is full, the unit then rotates its ring of MAX_PARTICLES storage cells
// through one full revolution, presenting one stored sphere per cycle to a single
// three-stage squared-distance unit. The result of a candidate is shown in the same cycle
// in which busy drops, so the next start can be taken at the end of that cycle. A
// candidate that arrives while the store is full is rejected with the full status on
// the very next cycle, without a sweep.
// The revolution length, and with it the rate, is set by the ring depth, not by how many
// spheres are stored. Each result is shown for exactly one cycle with o_result_valid
// high; the receiver cannot hold it off and must take it then. The contact distance
// register may only be written while busy is low and no result is pending.
module hard_sphere_insertion_check_unit #(
    parameter int unsigned MAX_PARTICLES = 128,
    parameter int unsigned COORD_BITS    = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      start,
    output logic                                      busy,
    input  logic signed [COORD_BITS-1:0]              i_pos_x,
    input  logic signed [COORD_BITS-1:0]              i_pos_y,
    input  logic signed [COORD_BITS-1:0]              i_pos_z,
    input  logic                                      i_cfg_wr_en,
    input  hsic_pkg::t_dist_sq                        i_cfg_wr_data,
    output logic                                      o_result_valid,
    output hsic_pkg::t_status                         o_status,
    output logic [$clog2(MAX_PARTICLES)-1:0]          o_placed_index,
    output logic [$clog2(MAX_PARTICLES+1)-1:0]        o_placed_count
);
    import hsic_pkg::*;

    localparam int unsigned IDX_W   = $clog2(MAX_PARTICLES);
    localparam int unsigned CNT_W   = $clog2(MAX_PARTICLES + 1);
    localparam int unsigned ENTRY_W = 3 * COORD_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DRAIN
    } t_state;

    t_state             r_state;
    logic [IDX_W-1:0]   r_step;
    logic [1:0]         r_drain;
    logic [CNT_W-1:0]   r_count;
    logic [ENTRY_W-1:0] r_cand;
    logic               r_overlap;
    t_dist_sq           r_dist_sq;
    logic               r_result_valid;
    t_status            r_status;
    logic [IDX_W-1:0]   r_index;
    logic [CNT_W-1:0]   r_placed;

    logic [ENTRY_W-1:0] w_ring [MAX_PARTICLES];
    logic [MAX_PARTICLES-1:0] w_load;
    logic               w_shift;
    logic               w_cmp_valid;
    logic               w_hit;
    logic               w_finish;
    logic               w_overlap;
    logic               w_accept;
    logic               w_full;

    // The ring rotates toward cell 0: after k shifts, cell 0 holds stored entry k.
    // Only entries below the current count are compared; the rest were never written.
    assign w_shift     = (r_state == S_SWEEP);
    assign w_cmp_valid = w_shift && (CNT_W'(r_step) < r_count);
    assign w_full      = (r_count == CNT_W'(MAX_PARTICLES));

    // The hit of the last compare leaves the distance unit while the drain counter is at two.
    assign w_finish  = (r_state == S_DRAIN) && (r_drain == 2'd2);
    assign w_overlap = r_overlap | w_hit;
    assign w_accept  = w_finish && !w_overlap;

    generate
        for (genvar g = 0; g < MAX_PARTICLES; g++) begin : g_cell
            // The ring is back at rest when a result is decided, so slot r_count is
            // sitting in its own cell.
            assign w_load[g] = w_accept && (r_count == CNT_W'(g));

            hsic_cell #(
                .ENTRY_W (ENTRY_W)
            ) u_cell (
                .i_clk       (i_clk),
                .i_shift     (w_shift),
                .i_load      (w_load[g]),
                .i_load_data (r_cand),
                .i_prev      (w_ring[(g + 1) % MAX_PARTICLES]),
                .o_data      (w_ring[g])
            );
        end
    endgenerate

    hsic_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cmp_valid),
        .i_cand  (r_cand),
        .i_entry (w_ring[0]),
        .i_limit (r_dist_sq),
        .o_hit   (w_hit)
    );

    // Contact distance register; writes must only be made while the unit is idle, which the block does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_sq <= CONTACT_RESET;
        end else if (i_cfg_wr_en) begin
            r_dist_sq <= i_cfg_wr_data;
        end
    end

    // Sequencer: state, sweep and drain counters, sphere count and the result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_step         <= '0;
            r_drain        <= '0;
            r_count        <= '0;
            r_overlap      <= 1'b0;
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cand <= {i_pos_x, i_pos_y, i_pos_z};
                        if (w_full) begin
                            // A full store rejects at once, with no sweep.
                            r_result_valid <= 1'b1;
                            r_status       <= ST_FULL;
                            r_index        <= '0;
                            r_placed       <= r_count;
                        end else begin
                            r_state   <= S_SWEEP;
                            r_step    <= '0;
                            r_overlap <= 1'b0;
                        end
                    end
                end
                S_SWEEP: begin
                    // Hits from the early compares already arrive during the sweep.
                    r_overlap <= w_overlap;
                    r_step    <= r_step + IDX_W'(1);
                    if (r_step == IDX_W'(MAX_PARTICLES - 1)) begin
                        r_state <= S_DRAIN;
                        r_drain <= '0;
                    end
                end
                S_DRAIN: begin
                    r_drain   <= r_drain + 2'd1;
                    r_overlap <= w_overlap;
                    if (w_finish) begin
                        r_state        <= S_IDLE;
                        r_result_valid <= 1'b1;
                        if (w_overlap) begin
                            r_status <= ST_OVERLAP;
                            r_index  <= '0;
                            r_placed <= r_count;
                        end else begin
                            r_status <= ST_ACCEPTED;
                            r_index  <= r_count[IDX_W-1:0];
                            r_placed <= r_count + CNT_W'(1);
                            r_count  <= r_count + CNT_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_result_valid;
    assign o_status       = r_status;
    assign o_placed_index = r_index;
    assign o_placed_count = r_placed;

endmodule

// ===== sv/hsic_checker.sv =====
// Port-level checks for the hard-sphere insertion check unit, bound to its top level.
// Depends on hsic_pkg and on the top level's port list.
module hsic_checker #(
    parameter int unsigned MAX_PARTICLES = 128
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               busy,
    input logic                               o_result_valid,
    input hsic_pkg::t_status                  o_status,
    input logic [$clog2(MAX_PARTICLES)-1:0]   o_placed_index,
    input logic [$clog2(MAX_PARTICLES+1)-1:0] o_placed_count
);
    import hsic_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_PARTICLES + 1);

    // No result may come out of a reset.
    a_no_result_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_result_valid)
        else $error("result strobe right after reset");

    // A result is always shown with the unit ready for the next transfer.
    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while busy");

    // A rejected candidate gets slot zero.
    a_reject_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status != ST_ACCEPTED)) |-> (o_placed_index == '0))
        else $error("rejected candidate reports a nonzero slot");

    // An accepted sphere is the last one stored.
    a_accept_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status == ST_ACCEPTED))
            |-> (o_placed_count == (CNT_W'(o_placed_index) + CNT_W'(1))))
        else $error("accepted slot does not match the sphere count");

    // A full rejection only happens with the store at capacity.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status == ST_FULL))
            |-> (o_placed_count == CNT_W'(MAX_PARTICLES)))
        else $error("full rejection below capacity");

endmodule

bind hard_sphere_insertion_check_unit hsic_checker #(
    .MAX_PARTICLES (MAX_PARTICLES)
) u_hsic_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_status       (o_status),
    .o_placed_index (o_placed_index),
    .o_placed_count (o_placed_count)
);

// ===== tb/sv/hard_sphere_insertion_check_unit_tb.sv =====
// Self-checking testbench for the hard-sphere insertion check unit.
// Depends on hsic_pkg and hard_sphere_insertion_check_unit, and through it on hsic_cell and hsic_dist.
// Candidates are sent under random gaps, none in a steady stretch, and a placement model predicts every result.
module hard_sphere_insertion_check_unit_tb;
    import hsic_pkg::*;

    localparam int unsigned MAX_PARTICLES = 128;
    localparam int unsigned COORD_BITS    = 16;
    localparam int unsigned IDX_W         = $clog2(MAX_PARTICLES);
    localparam int unsigned CNT_W         = $clog2(MAX_PARTICLES + 1);
    localparam int          RANDOM_ITEMS  = 1950;
    localparam int          RANDOM_PHASES = 5;
    // The random part aims to have the store full around this item, so that the
    // tail of the run exercises the store-full rejection.
    localparam int          TARGET_FILL   = 1700;
    localparam int          CYCLE_LIMIT   = 2000000;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    // One predicted result, in the order the block must report it.
    typedef struct {
        t_status            status;
        logic [IDX_W-1:0]   index;
        logic [CNT_W-1:0]   count;
    } t_placement;

    // Keeps its own copy of the stored spheres and the contact distance, works out
    // the outcome of every candidate when its transfer happens, and compares the
    // reported results against those outcomes in order.
    class sphere_placement_board;
        t_coord          kept_x [MAX_PARTICLES];
        t_coord          kept_y [MAX_PARTICLES];
        t_coord          kept_z [MAX_PARTICLES];
        int unsigned     kept;
        t_dist_sq        contact;
        t_placement      placements_due [$];
        int unsigned     errors;

        function new();
            kept    = 0;
            contact = CONTACT_RESET;
            errors  = 0;
        endfunction

        function void set_contact(t_dist_sq value);
            contact = value;
        endfunction

        // Squared distances are exact: each axis difference is squared in 64 bits,
        // and a distance equal to the contact distance still counts as overlap.
        function void note_candidate(t_coord x, t_coord y, t_coord z);
            t_placement  p;
            longint      dx;
            longint      dy;
            longint      dz;
            bit          hit;
            int unsigned j;
            hit     = 1'b0;
            p.index = '0;
            if (kept >= MAX_PARTICLES) begin
                p.status = ST_FULL;
            end else begin
                for (j = 0; j < kept; j++) begin
                    dx = longint'(x) - longint'(kept_x[j]);
                    dy = longint'(y) - longint'(kept_y[j]);
                    dz = longint'(z) - longint'(kept_z[j]);
                    if (dx * dx + dy * dy + dz * dz <= longint'(contact)) hit = 1'b1;
                end
                if (hit) begin
                    p.status = ST_OVERLAP;
                end else begin
                    p.status     = ST_ACCEPTED;
                    p.index      = IDX_W'(kept);
                    kept_x[kept] = x;
                    kept_y[kept] = y;
                    kept_z[kept] = z;
                    kept++;
                end
            end
            p.count = CNT_W'(kept);
            placements_due.push_back(p);
        endfunction

        function void check_placement(t_status status, logic [IDX_W-1:0] index,
                                      logic [CNT_W-1:0] count);
            t_placement p;
            if (placements_due.size() == 0) begin
                $display("%0t: result with no candidate pending: status %0d index %0d count %0d",
                         $time, status, index, count);
                errors++;
                return;
            end
            p = placements_due.pop_front();
            if (status !== p.status) begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, p.status, status);
                errors++;
            end
            if (index !== p.index) begin
                $display("%0t: placed_index mismatch: expected %0d actual %0d",
                         $time, p.index, index);
                errors++;
            end
            if (count !== p.count) begin
                $display("%0t: placed_count mismatch: expected %0d actual %0d",
                         $time, p.count, count);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return placements_due.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_coord             i_pos_x;
    t_coord             i_pos_y;
    t_coord             i_pos_z;
    logic               i_cfg_wr_en;
    t_dist_sq           i_cfg_wr_data;
    logic               o_result_valid;
    t_status            o_status;
    logic [IDX_W-1:0]   o_placed_index;
    logic [CNT_W-1:0]   o_placed_count;

    sphere_placement_board board;
    int                    cycles;
    // While set, the sender puts no gap between candidates.
    bit                    steady;

    hard_sphere_insertion_check_unit #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .COORD_BITS    (COORD_BITS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_placed_index (o_placed_index),
        .o_placed_count (o_placed_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // The watchdog ends a run that hangs; the limit is several times the slowest
    // correct run, where every candidate pays the full sweep plus the longest gap.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("hard_sphere_insertion_check_unit_tb: FAIL");
            $finish;
        end
    end

    // A result is shown for one cycle only and is taken at the edge that ends it.
    // Sampling right at the edge sees the values of the cycle that just ended.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            board.check_placement(o_status, o_placed_index, o_placed_count);
        end
    end

    // Offers one candidate and returns at the edge of its transfer, with start still
    // high, so a following candidate without a gap keeps start high throughout.
    // Gaps are mostly short, but now and then long enough to fall anywhere in a sweep.
    task automatic send_candidate(t_coord x, t_coord y, t_coord z);
        int gap;
        gap = 0;
        if (!steady) begin
            if ($urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 150);
            end else begin
                while ($urandom_range(0, 99) < 37) gap++;
            end
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_pos_x <= x;
        i_pos_y <= y;
        i_pos_z <= z;
        do @(posedge i_clk); while (busy);
        board.note_candidate(x, y, z);
    endtask

    // The sender holds off until every predicted result has come and the unit is idle.
    task automatic drain();
        start <= 1'b0;
        while (board.pending() != 0 || busy !== 1'b0) @(posedge i_clk);
    endtask

    // Only called with the unit idle, so the new contact distance applies to every
    // later candidate and to none before.
    task automatic write_contact(t_dist_sq value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        board.set_contact(value);
    endtask

    initial begin
        int          i;
        int          phase;
        int          per_phase;
        int          lim;
        int unsigned j;
        int          need;
        int          left;
        t_coord      x;
        t_coord      y;
        t_coord      z;

        board         = new();
        cycles        = 0;
        steady        = 1'b0;
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_pos_x       <= '0;
        i_pos_y       <= '0;
        i_pos_z       <= '0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, first under the reset contact distance of 1024^2.
        // The first candidate goes into slot 0 of the empty store, and the same
        // point again overlaps it.
        send_candidate(16'sd0, 16'sd0, 16'sd0);
        send_candidate(16'sd0, 16'sd0, 16'sd0);
        // Exactly at the contact distance counts as overlap; one step further does not.
        send_candidate(16'sd1024, 16'sd0, 16'sd0);
        send_candidate(16'sd1025, 16'sd0, 16'sd0);
        // Corners of the coordinate range.
        send_candidate(16'sd32767, 16'sd32767, 16'sd32767);
        send_candidate(-16'sd32768, -16'sd32768, -16'sd32768);
        send_candidate(16'sd32767, -16'sd32768, 16'sd32767);
        send_candidate(-16'sd32768, 16'sd32767, -16'sd32768);
        send_candidate(-16'sd32768, -16'sd32768, -16'sd32767);
        drain();

        // With a zero contact distance only an identical point overlaps.
        write_contact('0);
        send_candidate(16'sd0, 16'sd0, 16'sd0);
        send_candidate(16'sd1, 16'sd0, 16'sd0);
        send_candidate(16'sd1, 16'sd0, 16'sd0);
        send_candidate(16'sd32767, 16'sd32767, 16'sd32766);
        drain();

        // The largest contact distance covers the whole coordinate cube, so even
        // opposite corners overlap.
        write_contact('1);
        send_candidate(16'sd100, -16'sd100, 16'sd50);
        send_candidate(-16'sd32768, -16'sd32768, -16'sd32768);
        send_candidate(16'sd32767, 16'sd32767, 16'sd32767);
        drain();

        // Random part. Most candidates are placed near a stored sphere, at an offset
        // scaled to the contact distance, so overlaps dominate and boundary distances
        // get hit; the rest are fresh points anywhere, spaced so that the store fills
        // near TARGET_FILL and the last stretch meets a full store.
        per_phase = RANDOM_ITEMS / RANDOM_PHASES;
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % per_phase == 0) begin
                phase = i / per_phase;
                drain();
                case (phase)
                    0:       write_contact(t_dist_sq'(4194304));
                    1:       write_contact(t_dist_sq'($urandom_range(1 << 16, 1 << 24)));
                    2:       write_contact('0);
                    3:       write_contact('1);
                    default: write_contact(CONTACT_RESET);
                endcase
            end
            steady = (i >= 200 && i < 450);

            need = MAX_PARTICLES - board.kept;
            left = TARGET_FILL - i;
            if (board.kept == 0 || (need > 0 && (left <= 0 || $urandom_range(1, left) <= need))
                || $urandom_range(0, 19) == 0) begin
                x = t_coord'($urandom);
                y = t_coord'($urandom);
                z = t_coord'($urandom);
            end else begin
                j   = $urandom_range(0, board.kept - 1);
                lim = int'($sqrt(real'(board.contact) / 3.0));
                if (lim > 0 && $urandom_range(0, 3) == 0) lim = lim + 1 + lim / 8;
                x = board.kept_x[j] + t_coord'($urandom_range(0, 2 * lim) - lim);
                y = board.kept_y[j] + t_coord'($urandom_range(0, 2 * lim) - lim);
                z = board.kept_z[j] + t_coord'($urandom_range(0, 2 * lim) - lim);
            end
            send_candidate(x, y, z);
        end

        // Let every outstanding result arrive, then allow one more sweep for any
        // result that the unit should not have produced.
        drain();
        repeat (MAX_PARTICLES + 8) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("hard_sphere_insertion_check_unit_tb: PASS");
        end else begin
            $display("hard_sphere_insertion_check_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
